/* sv/mwsk_pkg.sv */
// ----------------------------------------------------------------------------
// Mecanum wheel speed kinematics package
// Field widths, register indexes, fixed-point constants and the angle
// quadrant split shared by the wheel speed pipeline.
// ----------------------------------------------------------------------------
package mwsk_pkg;

    localparam int HEADING_W = 12;
    localparam int SPEED_W   = 16;
    localparam int TURN_W    = 13;
    localparam int ARM_W     = 16;
    localparam int WHEEL_W   = 16;
    localparam int NUM_WHEELS = 8;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = NUM_WHEELS * WHEEL_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int SINE_W       = 15;
    localparam int TURN_ARM_W   = 30;
    localparam int ROT_PROD_W   = 51;
    localparam int ROT_W        = 33;
    localparam int VEL_W        = 32;
    localparam int SUM_W        = 35;
    localparam int MAG_W        = 34;
    localparam int SCALED_W     = 50;
    localparam int WHEEL_SHIFT  = 27;
    localparam int ROT_SHIFT    = 17;
    localparam int QUOTIENT_W   = SCALED_W - WHEEL_SHIFT;
    localparam int TAYLOR_TERMS = 6;

    localparam int HEADING_QUARTER = 900;
    localparam int ANGLE_REM_W     = 10;

    localparam logic [HEADING_W-1:0]   HEADING_FULL  = 12'd3600;
    localparam logic [HEADING_W:0]     HEADING_FULL_X = 13'd3600;
    localparam logic [HEADING_W:0]     HEADING_QTR_X  = 13'd900;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [20:0] PI_OVER_18000_Q32 = 21'sd749613;
    localparam logic [ROT_PROD_W-1:0] ROT_ROUND_HALF = 51'h10000;

    localparam logic [ARM_W-1:0] LEVER_FRONT_RESET = 16'd15535;
    localparam logic [ARM_W-1:0] LEVER_REAR_RESET  = 16'd21635;
    localparam logic [ARM_W-1:0] WHEEL_SCALE_RESET = 16'd7827;

    localparam logic [WHEEL_W-1:0] WHEEL_POS_MAX = 16'h7fff;
    localparam logic [WHEEL_W-1:0] WHEEL_NEG_MAX = 16'h8000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEVER_FRONT = 2'd0,
        CFG_LEVER_REAR  = 2'd1,
        CFG_WHEEL_SCALE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]             quadrant;
        logic [ANGLE_REM_W-1:0] remainder;
    } angle_split_t;

    function automatic angle_split_t split_angle(input logic [HEADING_W-1:0] angle);
        angle_split_t res;
        if (angle >= 12'd2700) begin
            res.quadrant  = 2'd3;
            res.remainder = ANGLE_REM_W'(angle - 12'd2700);
        end else if (angle >= 12'd1800) begin
            res.quadrant  = 2'd2;
            res.remainder = ANGLE_REM_W'(angle - 12'd1800);
        end else if (angle >= 12'd900) begin
            res.quadrant  = 2'd1;
            res.remainder = ANGLE_REM_W'(angle - 12'd900);
        end else begin
            res.quadrant  = 2'd0;
            res.remainder = ANGLE_REM_W'(angle);
        end
        return res;
    endfunction

endpackage

/* sv/mecanum_wheel_speed_kinematics_top.sv */
// ----------------------------------------------------------------------------
// Mecanum wheel speed kinematics
// Eight-stage pipeline turning heading, speed and turn rate into eight
// saturated wheel speeds for two wheel groups.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transfer: tdata = heading_tenths[11:0],
//   speed[27:12], turn_rate_tenths[40:28]; tuser = body_stop, remote_stop,
//   remote_timeout. m_* carries the eight wheel speeds, 16 bits each, wheel 1
//   in the lowest bits. cfg_* writes lever arm A (index 0), lever arm B
//   (index 1) and the Q4.12 wheel scale (index 2); it is always ready. The
//   user must write it only while the pipeline is empty; the block does not
//   enforce this itself. While m_tready stays high, one command per
//   cycle is sustained. Each of the eight register stages holds one item and
//   advances on its own enable; the multiply stages (turn times arm, times
//   the pi/18000 constant, velocity products, wheel scale) and the two
//   registered table reads set the stage split.
//   Reset clears all stage valid bits and loads the register defaults; the
//   sine and index tables are constant ROMs and need no fill time.
//   When m_tready is low the output holds; earlier stages keep accepting
//   until every bubble is filled, then s_tready drops.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_kinematics_top
    import mwsk_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // heading_tenths[11:0], speed[27:12], turn_rate_tenths[40:28], zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // body_stop[0], remote_stop[1], remote_timeout[2]
    input  logic [S_TUSER_W-1:0]   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // wheel_speed_1[15:0], wheel_speed_2[31:16], ... wheel_speed_8[127:112]
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SINE_TABLE_DEPTH);

    typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];
    typedef logic [IDX_W-1:0]  index_rom_t [HEADING_QUARTER];

    // Taylor term n is divided by (2n)(2n+1)
    function automatic longint unsigned taylor_divide(input longint unsigned term,
                                                      input int n);
        longint unsigned res;
        case (n)
            1:       res = term / 64'd6;
            2:       res = term / 64'd20;
            3:       res = term / 64'd42;
            4:       res = term / 64'd72;
            5:       res = term / 64'd110;
            default: res = term / 64'd156;
        endcase
        return res;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            term = x;
            sum  = x;
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = taylor_divide(term, n);
                if ((n & 1) != 0) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = SINE_W'(v);
        end
        return rom;
    endfunction

    function automatic index_rom_t build_index_rom();
        index_rom_t rom;
        longint     v;
        for (int r = 0; r < HEADING_QUARTER; r++) begin
            v = (longint'(r) * SINE_TABLE_DEPTH + 450) / 900;
            if (v > SINE_TABLE_DEPTH) begin
                v = SINE_TABLE_DEPTH;
            end
            rom[r] = IDX_W'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t  SINE_ROM  = build_sine_rom();
    localparam index_rom_t INDEX_ROM = build_index_rom();

    // configuration registers
    logic [ARM_W-1:0] lever_front_reg;
    logic [ARM_W-1:0] lever_rear_reg;
    logic [ARM_W-1:0] wheel_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lever_front_reg <= LEVER_FRONT_RESET;
            lever_rear_reg  <= LEVER_REAR_RESET;
            wheel_scale_reg <= WHEEL_SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LEVER_FRONT: lever_front_reg <= cfg_data;
                CFG_LEVER_REAR:  lever_rear_reg  <= cfg_data;
                CFG_WHEEL_SCALE: wheel_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en8;

    always_comb begin
        en8 = !s8_valid_reg || m_tready;
        en7 = !s7_valid_reg || en8;
        en6 = !s6_valid_reg || en7;
        en5 = !s5_valid_reg || en6;
        en4 = !s4_valid_reg || en5;
        en3 = !s3_valid_reg || en4;
        en2 = !s2_valid_reg || en3;
        en1 = !s1_valid_reg || en2;
    end

    assign s_tready = en1;
    assign m_tvalid = s8_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end else begin
            if (en1) s1_valid_reg <= s_tvalid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
            if (en7) s7_valid_reg <= s6_valid_reg;
            if (en8) s8_valid_reg <= s7_valid_reg;
        end
    end

    // stage 1: angle reduction, turn times lever arms
    logic [HEADING_W-1:0]        in_heading;
    logic signed [SPEED_W-1:0]   in_speed;
    logic signed [TURN_W-1:0]    in_turn;
    logic [HEADING_W:0]          cos_sum;
    logic [HEADING_W-1:0]        s1_hs_next, s1_hc_next;

    assign in_heading = s_tdata[11:0];
    assign in_speed   = s_tdata[27:12];
    assign in_turn    = s_tdata[40:28];
    assign cos_sum    = {1'b0, in_heading} + HEADING_QTR_X;
    assign s1_hs_next = (in_heading >= HEADING_FULL) ? in_heading - HEADING_FULL : in_heading;
    assign s1_hc_next = (cos_sum >= HEADING_FULL_X) ? HEADING_W'(cos_sum - HEADING_FULL_X)
                                                    : cos_sum[HEADING_W-1:0];

    logic [HEADING_W-1:0]         s1_hs_reg, s1_hc_reg;
    logic signed [SPEED_W-1:0]    s1_speed_reg;
    logic signed [TURN_ARM_W-1:0] s1_turn_a_reg, s1_turn_b_reg;
    logic                         s1_stop_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_hs_reg     <= s1_hs_next;
            s1_hc_reg     <= s1_hc_next;
            s1_speed_reg  <= in_speed;
            s1_turn_a_reg <= in_turn * $signed({1'b0, lever_front_reg});
            s1_turn_b_reg <= in_turn * $signed({1'b0, lever_rear_reg});
            s1_stop_reg   <= |s_tuser;
        end
    end

    // stage 2: quadrant split, index table read, rotation product
    angle_split_t split_sin, split_cos;

    assign split_sin = split_angle(s1_hs_reg);
    assign split_cos = split_angle(s1_hc_reg);

    logic [1:0]                   s2_q_sin_reg, s2_q_cos_reg;
    logic [IDX_W-1:0]             s2_idx_sin_reg, s2_idx_cos_reg;
    logic signed [SPEED_W-1:0]    s2_speed_reg;
    logic signed [ROT_PROD_W-1:0] s2_prod_a_reg, s2_prod_b_reg;
    logic                         s2_stop_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_q_sin_reg   <= split_sin.quadrant;
            s2_q_cos_reg   <= split_cos.quadrant;
            s2_idx_sin_reg <= INDEX_ROM[split_sin.remainder];
            s2_idx_cos_reg <= INDEX_ROM[split_cos.remainder];
            s2_speed_reg   <= s1_speed_reg;
            s2_prod_a_reg  <= s1_turn_a_reg * PI_OVER_18000_Q32;
            s2_prod_b_reg  <= s1_turn_b_reg * PI_OVER_18000_Q32;
            s2_stop_reg    <= s1_stop_reg;
        end
    end

    // stage 3: mirrored sine table read, rounding of rotation terms
    logic [IDX_W-1:0]      addr_sin, addr_cos;
    logic [ROT_PROD_W-1:0] round_a, round_b;

    assign addr_sin = s2_q_sin_reg[0] ? DEPTH_IDX - s2_idx_sin_reg : s2_idx_sin_reg;
    assign addr_cos = s2_q_cos_reg[0] ? DEPTH_IDX - s2_idx_cos_reg : s2_idx_cos_reg;
    assign round_a  = s2_prod_a_reg + ROT_ROUND_HALF
                    - ROT_PROD_W'(s2_prod_a_reg[ROT_PROD_W-1]);
    assign round_b  = s2_prod_b_reg + ROT_ROUND_HALF
                    - ROT_PROD_W'(s2_prod_b_reg[ROT_PROD_W-1]);

    logic [SINE_W-1:0]         s3_mag_sin_reg, s3_mag_cos_reg;
    logic                      s3_neg_sin_reg, s3_neg_cos_reg;
    logic signed [SPEED_W-1:0] s3_speed_reg;
    logic signed [ROT_W-1:0]   s3_w_a_reg, s3_w_b_reg;
    logic                      s3_stop_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_mag_sin_reg <= SINE_ROM[addr_sin];
            s3_mag_cos_reg <= SINE_ROM[addr_cos];
            s3_neg_sin_reg <= s2_q_sin_reg[1];
            s3_neg_cos_reg <= s2_q_cos_reg[1];
            s3_speed_reg   <= s2_speed_reg;
            s3_w_a_reg     <= round_a[ROT_SHIFT+ROT_W-1:ROT_SHIFT];
            s3_w_b_reg     <= round_b[ROT_SHIFT+ROT_W-1:ROT_SHIFT];
            s3_stop_reg    <= s2_stop_reg;
        end
    end

    // stage 4: velocity components
    logic signed [SINE_W:0] sin_val, cos_val;

    always_comb begin
        sin_val = $signed({1'b0, s3_mag_sin_reg});
        cos_val = $signed({1'b0, s3_mag_cos_reg});
        if (s3_neg_sin_reg) sin_val = -sin_val;
        if (s3_neg_cos_reg) cos_val = -cos_val;
    end

    logic signed [VEL_W-1:0] s4_vx_reg, s4_vy_reg;
    logic signed [ROT_W-1:0] s4_w_a_reg, s4_w_b_reg;
    logic                    s4_stop_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_vx_reg   <= cos_val * s3_speed_reg;
            s4_vy_reg   <= sin_val * s3_speed_reg;
            s4_w_a_reg  <= s3_w_a_reg;
            s4_w_b_reg  <= s3_w_b_reg;
            s4_stop_reg <= s3_stop_reg;
        end
    end

    // stage 5: wheel sums, group A on wheels 1-4, group B on 5-8
    logic signed [SUM_W-1:0] s5_sum_next [NUM_WHEELS];
    logic signed [SUM_W-1:0] vx_ext, vy_ext, wa_ext, wb_ext;

    always_comb begin
        vx_ext = SUM_W'(s4_vx_reg);
        vy_ext = SUM_W'(s4_vy_reg);
        wa_ext = SUM_W'(s4_w_a_reg);
        wb_ext = SUM_W'(s4_w_b_reg);
        s5_sum_next[0] =  vy_ext + vx_ext - wa_ext;
        s5_sum_next[1] =  vy_ext - vx_ext - wa_ext;
        s5_sum_next[2] =  vx_ext - vy_ext - wa_ext;
        s5_sum_next[3] = -vy_ext - vx_ext - wa_ext;
        s5_sum_next[4] =  vy_ext + vx_ext - wb_ext;
        s5_sum_next[5] =  vy_ext - vx_ext - wb_ext;
        s5_sum_next[6] =  vx_ext - vy_ext - wb_ext;
        s5_sum_next[7] = -vy_ext - vx_ext - wb_ext;
    end

    logic signed [SUM_W-1:0] s5_sum_reg [NUM_WHEELS];
    logic                    s5_stop_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            s5_sum_reg  <= s5_sum_next;
            s5_stop_reg <= s4_stop_reg;
        end
    end

    // stage 6: sign and magnitude
    logic [MAG_W-1:0]      s6_mag_next [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] s6_neg_next;
    logic [SUM_W-1:0]      neg_sum [NUM_WHEELS];

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            neg_sum[k]     = -s5_sum_reg[k];
            s6_neg_next[k] = s5_sum_reg[k][SUM_W-1];
            s6_mag_next[k] = s6_neg_next[k] ? neg_sum[k][MAG_W-1:0]
                                            : s5_sum_reg[k][MAG_W-1:0];
        end
    end

    logic [MAG_W-1:0]      s6_mag_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] s6_neg_reg;
    logic                  s6_stop_reg;

    always_ff @(posedge aclk) begin
        if (en6) begin
            s6_mag_reg  <= s6_mag_next;
            s6_neg_reg  <= s6_neg_next;
            s6_stop_reg <= s5_stop_reg;
        end
    end

    // stage 7: wheel scale
    logic [SCALED_W-1:0]   s7_prod_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] s7_neg_reg;
    logic                  s7_stop_reg;

    always_ff @(posedge aclk) begin
        if (en7) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                s7_prod_reg[k] <= s6_mag_reg[k] * wheel_scale_reg;
            end
            s7_neg_reg  <= s6_neg_reg;
            s7_stop_reg <= s6_stop_reg;
        end
    end

    // stage 8: truncate, saturate, stop override
    logic [M_TDATA_W-1:0]  s8_data_next;
    logic [QUOTIENT_W-1:0] quot [NUM_WHEELS];
    logic [WHEEL_W-1:0]    wheel [NUM_WHEELS];

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            quot[k] = s7_prod_reg[k][SCALED_W-1:WHEEL_SHIFT];
            if (s7_neg_reg[k]) begin
                wheel[k] = (quot[k] > QUOTIENT_W'(WHEEL_NEG_MAX)) ? WHEEL_NEG_MAX
                                                                   : WHEEL_W'(-quot[k]);
            end else begin
                wheel[k] = (quot[k] > QUOTIENT_W'(WHEEL_POS_MAX)) ? WHEEL_POS_MAX
                                                                   : quot[k][WHEEL_W-1:0];
            end
            if (s7_stop_reg) begin
                wheel[k] = '0;
            end
            s8_data_next[k*WHEEL_W +: WHEEL_W] = wheel[k];
        end
    end

    logic [M_TDATA_W-1:0] s8_data_reg;

    always_ff @(posedge aclk) begin
        if (en8) begin
            s8_data_reg <= s8_data_next;
        end
    end

    assign m_tdata = s8_data_reg;

`ifndef SYNTHESIS
    a_ready_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while the output side is ready");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stop_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s7_valid_reg && s7_stop_reg && en8) |=> (m_tdata == '0))
        else $error("stop request produced a nonzero wheel speed");
`endif

endmodule

/* tb/sv/mwsk_wheel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed checker
// Watches the command, result and register channels of the mecanum
// kinematics block. Predicts the eight wheel speeds of every accepted
// command from its own sine table and register copies, then compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mwsk_wheel_checker
    import mwsk_pkg::*;
#(
    parameter int SINE_DEPTH = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     error_count,
    output int                     outstanding,
    output int                     wheel_sets_seen,
    output int                     saturated_sets
);

    localparam int FULL_TURN  = 4 * HEADING_QUARTER;
    localparam int PRINT_CAP  = 40;

    int                      sine_lut [0:SINE_DEPTH];
    logic [ARM_W-1:0]        arm_front = LEVER_FRONT_RESET;
    logic [ARM_W-1:0]        arm_rear  = LEVER_REAR_RESET;
    logic [ARM_W-1:0]        wheel_scale = WHEEL_SCALE_RESET;
    logic [M_TDATA_W-1:0]    expected_wheel_sets [$];

    initial begin
        error_count     = 0;
        outstanding     = 0;
        wheel_sets_seen = 0;
        saturated_sets  = 0;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            sine_lut[k] = sine_entry(k);
        end
    end

    // Taylor series of sin up to x^13 in unsigned Q30, rounded to Q1.15
    function automatic int sine_entry(longint unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned v;
        x    = (k * HALF_PI_Q30) / longint'(SINE_DEPTH);
        term = x;
        acc  = x;
        for (longint unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n[0]) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return int'(v);
    endfunction

    function automatic longint sine_at(int unsigned angle);
        int unsigned q;
        int unsigned r;
        int unsigned i;
        longint      v;
        q = angle / HEADING_QUARTER;
        r = angle % HEADING_QUARTER;
        i = (r * SINE_DEPTH + HEADING_QUARTER / 2) / HEADING_QUARTER;
        if (i > SINE_DEPTH) begin
            i = SINE_DEPTH;
        end
        if (q[0]) begin
            i = SINE_DEPTH - i;
        end
        v = sine_lut[i];
        return (q >= 2) ? -v : v;
    endfunction

    // turn * arm * pi/18000, rounded half away from zero to Q15
    function automatic longint rotation_q15(longint turn, logic [ARM_W-1:0] arm);
        longint prod;
        longint mag;
        prod = turn * longint'(arm) * longint'(PI_OVER_18000_Q32);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (64'sd1 <<< (ROT_SHIFT - 1))) >>> ROT_SHIFT;
        return (prod < 0) ? -mag : mag;
    endfunction

    function automatic logic [WHEEL_W-1:0] scale_saturate(longint lin);
        longint mag;
        mag = (lin < 0) ? -lin : lin;
        mag = (mag * longint'(wheel_scale)) >>> WHEEL_SHIFT;
        if (lin < 0) begin
            return (mag > 32768) ? WHEEL_NEG_MAX : WHEEL_W'(-mag);
        end
        return (mag > 32767) ? WHEEL_POS_MAX : WHEEL_W'(mag);
    endfunction

    function automatic logic [M_TDATA_W-1:0] predict_wheel_speeds(
        logic [S_TDATA_W-1:0] cmd,
        logic [S_TUSER_W-1:0] stops
    );
        logic [M_TDATA_W-1:0]      wheels;
        logic signed [SPEED_W-1:0] speed_f;
        logic signed [TURN_W-1:0]  turn_f;
        int unsigned               heading;
        longint                    speed;
        longint                    turn;
        longint                    vx;
        longint                    vy;
        longint                    rot_a;
        longint                    rot_b;
        wheels = '0;
        if (stops != '0) begin
            return wheels;
        end
        heading = cmd[HEADING_W-1:0];
        if (heading >= FULL_TURN) begin
            heading -= FULL_TURN;
        end
        speed_f = cmd[HEADING_W +: SPEED_W];
        turn_f  = cmd[HEADING_W + SPEED_W +: TURN_W];
        speed   = speed_f;
        turn    = turn_f;
        vx      = sine_at((heading + HEADING_QUARTER) % FULL_TURN) * speed;
        vy      = sine_at(heading) * speed;
        rot_a   = rotation_q15(turn, arm_front);
        rot_b   = rotation_q15(turn, arm_rear);
        wheels[0*WHEEL_W +: WHEEL_W] = scale_saturate(vy + vx - rot_a);
        wheels[1*WHEEL_W +: WHEEL_W] = scale_saturate(vy - vx - rot_a);
        wheels[2*WHEEL_W +: WHEEL_W] = scale_saturate(-(vy - vx + rot_a));
        wheels[3*WHEEL_W +: WHEEL_W] = scale_saturate(-(vy + vx + rot_a));
        wheels[4*WHEEL_W +: WHEEL_W] = scale_saturate(vy + vx - rot_b);
        wheels[5*WHEEL_W +: WHEEL_W] = scale_saturate(vy - vx - rot_b);
        wheels[6*WHEEL_W +: WHEEL_W] = scale_saturate(-(vy - vx + rot_b));
        wheels[7*WHEEL_W +: WHEEL_W] = scale_saturate(-(vy + vx + rot_b));
        return wheels;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("%0t ns: MISMATCH %s", $realtime, msg);
        end
        error_count++;
    endtask

    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] expected;
        logic                 at_limit;
        if (!aresetn) begin
            arm_front   = LEVER_FRONT_RESET;
            arm_rear    = LEVER_REAR_RESET;
            wheel_scale = WHEEL_SCALE_RESET;
            expected_wheel_sets.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LEVER_FRONT: arm_front   = cfg_data;
                    CFG_LEVER_REAR:  arm_rear    = cfg_data;
                    CFG_WHEEL_SCALE: wheel_scale = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_wheel_sets.push_back(predict_wheel_speeds(s_tdata, s_tuser));
            end
            if (m_tvalid && m_tready) begin
                wheel_sets_seen++;
                if (expected_wheel_sets.size() == 0) begin
                    report_mismatch($sformatf("wheel set %0h with no command pending",
                                              m_tdata));
                end else begin
                    expected = expected_wheel_sets.pop_front();
                    at_limit = 1'b0;
                    for (int w = 0; w < NUM_WHEELS; w++) begin
                        if (expected[w*WHEEL_W +: WHEEL_W] == WHEEL_POS_MAX ||
                            expected[w*WHEEL_W +: WHEEL_W] == WHEEL_NEG_MAX) begin
                            at_limit = 1'b1;
                        end
                        if (m_tdata[w*WHEEL_W +: WHEEL_W] !== expected[w*WHEEL_W +: WHEEL_W]) begin
                            report_mismatch($sformatf(
                                "wheel_speed_%0d of set %0d: got %0d, expected %0d",
                                w + 1, wheel_sets_seen,
                                $signed(m_tdata[w*WHEEL_W +: WHEEL_W]),
                                $signed(expected[w*WHEEL_W +: WHEEL_W])));
                        end
                    end
                    if (at_limit) begin
                        saturated_sets++;
                    end
                end
            end
            outstanding <= expected_wheel_sets.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel speed kinematics testbench
// Drives directed and random motion commands through the block under a
// range of lever arm and wheel scale settings, with random idling on both
// stream sides, a long output stall and a full drain. The checker beside
// the block predicts and compares every wheel set.
// ----------------------------------------------------------------------------
module tb_top;
    import mwsk_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int SINE_DEPTH     = 1024;
    localparam int PIPE_LATENCY   = 8;
    localparam int IDLE_PERCENT   = 31;
    localparam int RANDOM_PER_SET = 210;
    localparam int NUM_SETTINGS   = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int error_count;
    int outstanding;
    int wheel_sets_seen;
    int saturated_sets;

    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    bit hold_req  = 1'b0;
    int commands_sent = 0;

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    mecanum_wheel_speed_kinematics_top #(
        .SINE_TABLE_DEPTH(SINE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mwsk_wheel_checker #(
        .SINE_DEPTH(SINE_DEPTH)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .wheel_sets_seen (wheel_sets_seen),
        .saturated_sets  (saturated_sets)
    );

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= !(sink_idle && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_cmd(int heading, int speed, int turn);
        return {7'b0, TURN_W'(turn), SPEED_W'(speed), HEADING_W'(heading)};
    endfunction

    task automatic send_cmd(input logic [S_TDATA_W-1:0] data,
                            input logic [S_TUSER_W-1:0] stops);
        while (src_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= stops;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        commands_sent++;
    endtask

    task automatic send_random_cmd();
        int heading;
        int speed;
        int turn;
        logic [S_TUSER_W-1:0] stops;
        case ($urandom_range(0, 9))
            0:       heading = $urandom_range(3600, 4095);
            1:       heading = 900 * $urandom_range(0, 3) + $urandom_range(0, 4);
            default: heading = $urandom_range(0, 3599);
        endcase
        case ($urandom_range(0, 3))
            0:       speed = $urandom;
            3:       speed = int'($urandom_range(0, 600)) - 300;
            default: speed = int'($urandom_range(0, 6000)) - 3000;
        endcase
        case ($urandom_range(0, 3))
            0:       turn = $urandom;
            1:       turn = int'($urandom_range(0, 200)) - 100;
            default: turn = int'($urandom_range(0, 7200)) - 3600;
        endcase
        stops = ($urandom_range(0, 9) == 0) ? S_TUSER_W'($urandom_range(1, 7)) : '0;
        send_cmd(pack_cmd(heading, speed, turn), stops);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [ARM_W-1:0] front,
                                 input logic [ARM_W-1:0] rear,
                                 input logic [ARM_W-1:0] scale);
        wait_results();
        repeat (PIPE_LATENCY) @(posedge aclk);
        write_reg(CFG_LEVER_FRONT, front);
        write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        write_reg(CFG_LEVER_REAR, rear);
        write_reg(CFG_WHEEL_SCALE, scale);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [ARM_W-1:0] front;
        logic [ARM_W-1:0] rear;
        logic [ARM_W-1:0] scale;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // axes, quadrant edges, folded headings, field extremes, stop flags
        send_cmd(pack_cmd(0, 32767, 0), 3'b000);
        send_cmd(pack_cmd(900, 32767, 0), 3'b000);
        send_cmd(pack_cmd(1800, -32768, 0), 3'b000);
        send_cmd(pack_cmd(2700, 32767, 0), 3'b000);
        send_cmd(pack_cmd(3599, 1000, 0), 3'b000);
        send_cmd(pack_cmd(3600, 1000, 0), 3'b000);
        send_cmd(pack_cmd(4095, -1000, 0), 3'b000);
        send_cmd(pack_cmd(450, 32767, 4095), 3'b000);
        send_cmd(pack_cmd(1350, -32768, -4096), 3'b000);
        send_cmd(pack_cmd(2250, 1234, 3600), 3'b000);
        send_cmd(pack_cmd(3150, -1234, -3600), 3'b000);
        send_cmd(pack_cmd(0, 0, 1), 3'b000);
        send_cmd(pack_cmd(0, 0, -1), 3'b000);
        send_cmd(pack_cmd(1, 1, 0), 3'b000);
        send_cmd(pack_cmd(899, -1, 0), 3'b000);
        send_cmd(pack_cmd(901, 20000, 100), 3'b000);
        send_cmd(pack_cmd(1000, 30000, 2000), 3'b001);
        send_cmd(pack_cmd(2000, -30000, -2000), 3'b010);
        send_cmd(pack_cmd(3000, 12345, 3000), 3'b100);
        send_cmd(pack_cmd(123, -32768, -4096), 3'b111);

        for (int set = 0; set < NUM_SETTINGS; set++) begin
            case (set)
                0: begin front = LEVER_FRONT_RESET; rear = LEVER_REAR_RESET;
                         scale = WHEEL_SCALE_RESET; end
                1: begin front = '0; rear = '0; scale = '0; end
                2: begin front = '1; rear = '1; scale = '1; end
                3: begin front = '0; rear = '1; scale = 16'd4096; end
                4: begin front = '1; rear = '0; scale = 16'd1; end
                default: begin
                    front = $urandom;
                    rear  = $urandom;
                    scale = $urandom_range(1, 16384);
                end
            endcase
            apply_setting(front, rear, scale);

            // no idling on either side for a whole setting
            if (set == 3) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            // long output stall while commands keep coming
            if (set == 4) begin
                src_idle = 1'b0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                if (set == 4 && n == 40) begin
                    src_idle = 1'b1;
                end
                if (set == 5 && n == RANDOM_PER_SET / 2) begin
                    wait_results();
                end
                send_random_cmd();
            end
            src_idle  = 1'b1;
            sink_idle = 1'b1;
        end

        wait_results();
        repeat (PIPE_LATENCY * 2) @(posedge aclk);

        $display("Sent %0d motion commands across %0d register settings plus reset values,",
                 commands_sent, NUM_SETTINGS);
        $display("checked %0d wheel sets, %0d of them with a wheel at a saturation limit.",
                 wheel_sets_seen, saturated_sets);
        if (error_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
sv/mwsk_pkg.sv
sv/mecanum_wheel_speed_kinematics_top.sv
tb/sv/mwsk_wheel_checker.sv
tb/sv/tb_top.sv
